>>> hw/rtl/i2cm_pkg.sv
package i2cm_pkg;

  localparam int UNIT_W = 16;
  localparam int POLL_W = 8;
  localparam int TIMER_W = UNIT_W + 1;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [UNIT_W-1:0] UNIT_TICKS_RST = 16'd100;
  localparam logic [POLL_W-1:0] ACK_POLL_RST = 8'd250;

  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TICKS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL = 1'd1;

  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_RD_ACK = 3'd4;
  localparam logic [2:0] OP_RD_NACK = 3'd5;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_START = 2'd1;
  localparam logic [1:0] FAULT_ACK_TMO = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ST_A,
    ST_ST_B,
    ST_SP_A,
    ST_SP_B,
    ST_WR_D,
    ST_WR_H,
    ST_WR_L,
    ST_AK_R,
    ST_AK_H,
    ST_RD_L,
    ST_RD_H,
    ST_RA_L,
    ST_RA_H
  } seq_state_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rd_data;
    logic       ack_ok;
    logic [1:0] fault;
  } res_t;

endpackage

>>> hw/rtl/i2cm_core.sv
module i2cm_core
  import i2cm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic [2:0]        op,
  input  logic [7:0]        wr_data,
  input  logic              sda_in,
  input  logic [UNIT_W-1:0] unit_ticks,
  input  logic [POLL_W-1:0] ack_poll_limit,
  output res_t              res
);

  seq_state_t         state_r, state_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic [3:0]         bit_cnt_r, bit_cnt_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [POLL_W-1:0]  poll_r, poll_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;
  logic               rd_ack_r, rd_ack_nxt;
  logic [7:0]         rd_hold_r, rd_hold_nxt;
  logic               ack_r, ack_nxt;
  logic [1:0]         fault_r, fault_nxt;
  logic               done;

  logic [UNIT_W-1:0]  unit;
  logic [TIMER_W-1:0] len1, len2;
  logic [3:0]         bc_inc;

  assign unit   = (unit_ticks == '0) ? UNIT_W'(1) : unit_ticks;
  assign len1   = {1'b0, unit};
  assign len2   = {unit, 1'b0};
  assign bc_inc = bit_cnt_r + 4'd1;

  always_comb begin
    state_nxt   = state_r;
    timer_nxt   = timer_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    poll_nxt    = poll_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    rd_ack_nxt  = rd_ack_r;
    rd_hold_nxt = rd_hold_r;
    ack_nxt     = ack_r;
    fault_nxt   = fault_r;
    done        = 1'b0;

    if (state_r == ST_IDLE) begin
      if (op >= OP_START && op <= OP_RD_NACK) begin
        fault_nxt = FAULT_NONE;
      end
      case (op)
        OP_START: begin
          sda_nxt = 1'b1;
          if (!sda_in) begin
            fault_nxt = FAULT_START;
            done      = 1'b1;
          end else begin
            scl_nxt   = 1'b1;
            state_nxt = ST_ST_A;
            timer_nxt = len1;
          end
        end
        OP_STOP: begin
          scl_nxt   = 1'b0;
          sda_nxt   = 1'b0;
          state_nxt = ST_SP_A;
          timer_nxt = len1;
        end
        OP_WRITE: begin
          scl_nxt     = 1'b0;
          shift_nxt   = wr_data;
          bit_cnt_nxt = 4'd0;
          sda_nxt     = wr_data[7];
          state_nxt   = ST_WR_D;
          timer_nxt   = len1;
        end
        OP_RD_ACK, OP_RD_NACK: begin
          rd_ack_nxt  = (op == OP_RD_ACK);
          scl_nxt     = 1'b0;
          sda_nxt     = 1'b1;
          bit_cnt_nxt = 4'd0;
          shift_nxt   = 8'd0;
          state_nxt   = ST_RD_L;
          timer_nxt   = len2;
        end
        default: begin
        end
      endcase
    end else if (timer_r > TIMER_W'(1)) begin
      timer_nxt = timer_r - TIMER_W'(1);
    end else begin
      case (state_r)
        ST_ST_A: begin
          sda_nxt   = 1'b0;
          state_nxt = ST_ST_B;
          timer_nxt = len1;
        end
        ST_ST_B: begin
          if (sda_in) begin
            fault_nxt = FAULT_START;
          end else begin
            scl_nxt = 1'b0;
          end
          state_nxt = ST_IDLE;
          done      = 1'b1;
        end
        ST_SP_A: begin
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          state_nxt = ST_SP_B;
          timer_nxt = len1;
        end
        ST_SP_B: begin
          state_nxt = ST_IDLE;
          done      = 1'b1;
        end
        ST_WR_D: begin
          scl_nxt   = 1'b1;
          state_nxt = ST_WR_H;
          timer_nxt = len1;
        end
        ST_WR_H: begin
          scl_nxt   = 1'b0;
          state_nxt = ST_WR_L;
          timer_nxt = len1;
        end
        ST_WR_L: begin
          shift_nxt   = {shift_r[6:0], 1'b0};
          bit_cnt_nxt = bc_inc;
          timer_nxt   = len1;
          if (bc_inc >= 4'd8) begin
            sda_nxt   = 1'b1;
            poll_nxt  = '0;
            state_nxt = ST_AK_R;
          end else begin
            sda_nxt   = shift_r[6];
            state_nxt = ST_WR_D;
          end
        end
        ST_AK_R: begin
          scl_nxt   = 1'b1;
          state_nxt = ST_AK_H;
          timer_nxt = len1;
        end
        ST_AK_H: begin
          if (!sda_in) begin
            scl_nxt   = 1'b0;
            ack_nxt   = 1'b1;
            state_nxt = ST_IDLE;
            done      = 1'b1;
          end else if (poll_r >= ack_poll_limit) begin
            ack_nxt   = 1'b0;
            fault_nxt = FAULT_ACK_TMO;
            scl_nxt   = 1'b0;
            sda_nxt   = 1'b0;
            state_nxt = ST_SP_A;
            timer_nxt = len1;
          end else begin
            poll_nxt  = poll_r + POLL_W'(1);
            state_nxt = ST_AK_H;
            timer_nxt = len1;
          end
        end
        ST_RD_L: begin
          scl_nxt   = 1'b1;
          shift_nxt = {shift_r[6:0], sda_in};
          state_nxt = ST_RD_H;
          timer_nxt = len2;
        end
        ST_RD_H: begin
          scl_nxt     = 1'b0;
          bit_cnt_nxt = bc_inc;
          if (bc_inc >= 4'd8) begin
            rd_hold_nxt = shift_r;
            sda_nxt     = !rd_ack_r;
            state_nxt   = ST_RA_L;
            timer_nxt   = len1;
          end else begin
            state_nxt = ST_RD_L;
            timer_nxt = len2;
          end
        end
        ST_RA_L: begin
          scl_nxt   = 1'b1;
          state_nxt = ST_RA_H;
          timer_nxt = len1;
        end
        ST_RA_H: begin
          scl_nxt   = 1'b0;
          state_nxt = ST_IDLE;
          done      = 1'b1;
        end
        default: begin
          state_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res.scl      = scl_nxt;
    res.sda_out  = sda_nxt;
    res.busy_res = (state_nxt != ST_IDLE);
    res.done_res = done;
    res.rd_data  = rd_hold_nxt;
    res.ack_ok   = ack_nxt;
    res.fault    = fault_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      timer_r   <= '0;
      bit_cnt_r <= '0;
      shift_r   <= '0;
      poll_r    <= '0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
      rd_ack_r  <= 1'b0;
      rd_hold_r <= '0;
      ack_r     <= 1'b0;
      fault_r   <= FAULT_NONE;
    end else if (en) begin
      state_r   <= state_nxt;
      timer_r   <= timer_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      poll_r    <= poll_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      rd_ack_r  <= rd_ack_nxt;
      rd_hold_r <= rd_hold_nxt;
      ack_r     <= ack_nxt;
      fault_r   <= fault_nxt;
    end
  end

endmodule

>>> hw/rtl/i2c_master_byte_engine_top.sv
// I2C master byte engine advanced by one item per clock tick unless stalled: each item
// carries an optional command and the sampled SDA level, and produces exactly one result
// item with the SCL/SDA levels, busy, done, read byte, ack flag and fault code. The result
// goes to the output register, or to the skid register if the output stalls. A two-entry
// output stage (result register plus skid register) lets an item enter while an earlier
// result is still stalled; in_stall rises only when both entries hold results. Phase
// lengths are counted in items: unit_ticks per unit, doubled for each half of a read bit.
module i2c_master_byte_engine_top
  import i2cm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_op,
  input  logic [7:0]            in_wr_data,
  input  logic                  in_sda_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_scl,
  output logic                  out_sda_out,
  output logic                  out_busy_res,
  output logic                  out_done_res,
  output logic [7:0]            out_rd_data,
  output logic                  out_ack_ok,
  output logic [1:0]            out_fault
);

  logic [UNIT_W-1:0] unit_ticks_r;
  logic [POLL_W-1:0] ack_poll_r;
  res_t              res;
  res_t              out_r;
  res_t              skid_r;
  logic              out_valid_r;
  logic              skid_valid_r;
  logic              in_fire;
  logic              out_fire;

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !skid_valid_r;
  assign out_fire = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_ticks_r <= UNIT_TICKS_RST;
      ack_poll_r   <= ACK_POLL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UNIT_TICKS: unit_ticks_r <= cfg_data[UNIT_W-1:0];
        CFG_ACK_POLL:   ack_poll_r   <= cfg_data[POLL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  i2cm_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (in_fire),
    .op             (in_op),
    .wr_data        (in_wr_data),
    .sda_in         (in_sda_in),
    .unit_ticks     (unit_ticks_r),
    .ack_poll_limit (ack_poll_r),
    .res            (res)
  );

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_r && out_stall) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire) begin
      if (out_valid_r && out_stall) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_scl      = out_r.scl;
  assign out_sda_out  = out_r.sda_out;
  assign out_busy_res = out_r.busy_res;
  assign out_done_res = out_r.done_res;
  assign out_rd_data  = out_r.rd_data;
  assign out_ack_ok   = out_r.ack_ok;
  assign out_fault    = out_r.fault;

endmodule

>>> hw/rtl/i2cm_checker.sv
module i2cm_checker
  import i2cm_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_scl,
  input logic       out_sda_out,
  input logic       out_busy_res,
  input logic       out_done_res,
  input logic [7:0] out_rd_data,
  input logic [1:0] out_fault
);

  // stall only while results are pending
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("in_stall high with no result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rd_data) && $stable(out_fault)
      && $stable(out_scl) && $stable(out_sda_out) && $stable(out_done_res))
    else $error("stalled result item changed");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done reported while still busy");

  a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fault == FAULT_NONE || out_fault == FAULT_START
      || out_fault == FAULT_ACK_TMO))
    else $error("undefined fault code");

endmodule

bind i2c_master_byte_engine_top i2cm_checker u_i2cm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_scl      (out_scl),
  .out_sda_out  (out_sda_out),
  .out_busy_res (out_busy_res),
  .out_done_res (out_done_res),
  .out_rd_data  (out_rd_data),
  .out_fault    (out_fault)
);
